FILE: hdl/bag_pkg.sv
// Shared widths, constants and controller/datapath interface types for the
// Bruck all-gather schedule unit. No dependencies.
package bag_pkg;

  // Field widths fixed by the interface.
  localparam int RANKS_W = 7;   // rank count register, internal rank/block values
  localparam int RANK_W  = 6;   // rank and block fields on the ports
  localparam int STEP_W  = 3;   // step number
  localparam int LOG_W   = 3;   // ceil(log2 p), at most 7
  localparam int POW_W   = 8;   // 2^k and stride masks, at most 128

  // Lowest legal rank count; smaller writes are clamped up to it.
  localparam logic [RANKS_W-1:0] MIN_RANKS = RANKS_W'(2);

  // Most block beats that one step can produce.
  localparam int MAX_OUT = 32;
  localparam int CNT_W   = $clog2(MAX_OUT + 1);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_RANKS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MY_RANK   = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // latch step, rank count and rank
    logic reduce;  // one subtract of the rank-modulo-p reduction
    logic setup;   // derive peers, masks and scan start points
    logic scan;    // examine one block
    logic finish;  // deliver the final beat
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mod_done;      // rank is below p
    logic step_invalid;  // step is not below k
    logic scan_done;     // last block examined this cycle
    logic fin_done;      // final beat written to the output register
  } sts_t;

endpackage

FILE: hdl/bruck_allgather_schedule_unit.sv
// Bruck all-gather schedule unit: takes a step number and returns the send
// and receive peers and the ascending list of blocks to send, one per output
// beat, with last set on the final beat. The rank is reduced modulo p by one
// subtraction per cycle, then the block scan examines one block per cycle,
// unless a found block must wait for the output register, up to the last of the p
// blocks or the MAX_OUT-th block found; then the final beat goes out. A step
// that is not below ceil(log2 p) skips the scan. A new step is taken once the
// previous one's final beat is in the output register, even before it is read.
// Depends on bag_pkg, bag_ctrl and bag_dp.
module bruck_allgather_schedule_unit #(
  parameter int MAX_RANKS = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration writes.
  input  logic                             cfg_we_i,
  input  logic [bag_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [bag_pkg::RANKS_W-1:0]      cfg_data_i,
  // Step requests.
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [bag_pkg::STEP_W-1:0]       step_i,
  // Schedule beats.
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [bag_pkg::RANK_W-1:0]       block_index_o,
  output logic                             has_block_o,
  output logic                             last_o,
  output logic [bag_pkg::RANK_W-1:0]       send_peer_o,
  output logic [bag_pkg::RANK_W-1:0]       recv_peer_o,
  output logic                             step_invalid_o
);

  localparam int PW       = bag_pkg::RANKS_W;
  localparam int PCAP     = (MAX_RANKS > (2 ** PW) - 1) ? (2 ** PW) - 1 : MAX_RANKS;
  localparam logic [PW-1:0] P_CAP = PW'(PCAP);

  logic [PW-1:0]              num_ranks_q;
  logic [bag_pkg::RANK_W-1:0] my_rank_q;
  logic [PW-1:0]              ranks_eff;

  bag_pkg::cmd_t cmd;
  bag_pkg::sts_t sts;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_ranks_q <= bag_pkg::MIN_RANKS;
      my_rank_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        bag_pkg::CFG_NUM_RANKS: num_ranks_q <= cfg_data_i;
        bag_pkg::CFG_MY_RANK:   my_rank_q   <= cfg_data_i[bag_pkg::RANK_W-1:0];
        default: ;
      endcase
    end
  end

  // Rank count clamped to the supported range.
  always_comb begin
    if (num_ranks_q < bag_pkg::MIN_RANKS) begin
      ranks_eff = bag_pkg::MIN_RANKS;
    end else if (num_ranks_q > P_CAP) begin
      ranks_eff = P_CAP;
    end else begin
      ranks_eff = num_ranks_q;
    end
  end

  bag_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bag_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .step_i         (step_i),
    .ranks_i        (ranks_eff),
    .my_rank_i      (my_rank_q),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .block_index_o  (block_index_o),
    .has_block_o    (has_block_o),
    .last_o         (last_o),
    .send_peer_o    (send_peer_o),
    .recv_peer_o    (recv_peer_o),
    .step_invalid_o (step_invalid_o)
  );

endmodule

FILE: hdl/bag_ctrl.sv
// Sequencing state machine of the Bruck all-gather schedule unit.
// Depends on bag_pkg for the command and status types.
module bag_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  bag_pkg::sts_t sts_i,
  output bag_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_SETUP,
    ST_SCAN,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;

  // Next state follows the datapath status.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_MOD;
      ST_MOD:    if (sts_i.mod_done) state_d = ST_SETUP;
      ST_SETUP:  state_d = sts_i.step_invalid ? ST_FINISH : ST_SCAN;
      ST_SCAN:   if (sts_i.scan_done) state_d = ST_FINISH;
      ST_FINISH: if (sts_i.fin_done) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Commands are decoded from the current state, load also from in_valid_i.
  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.reduce = (state_q == ST_MOD);
    cmd_o.setup  = (state_q == ST_SETUP);
    cmd_o.scan   = (state_q == ST_SCAN);
    cmd_o.finish = (state_q == ST_FINISH);
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

FILE: hdl/bag_dp.sv
// Datapath of the Bruck all-gather schedule unit: rank reduction, peer and
// stride math, the block scan with its one-entry hold stage and the output register.
// Depends on bag_pkg for widths and the command and status types.
module bag_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bag_pkg::cmd_t                 cmd_i,
  output bag_pkg::sts_t                 sts_o,
  input  logic [bag_pkg::STEP_W-1:0]    step_i,
  input  logic [bag_pkg::RANKS_W-1:0]   ranks_i,
  input  logic [bag_pkg::RANK_W-1:0]    my_rank_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bag_pkg::RANK_W-1:0]    block_index_o,
  output logic                          has_block_o,
  output logic                          last_o,
  output logic [bag_pkg::RANK_W-1:0]    send_peer_o,
  output logic [bag_pkg::RANK_W-1:0]    recv_peer_o,
  output logic                          step_invalid_o
);

  localparam int PW = bag_pkg::RANKS_W;
  localparam int QW = bag_pkg::POW_W;
  localparam int KW = bag_pkg::LOG_W;
  localparam int CW = bag_pkg::CNT_W;

  // Number of bits needed to hold p-1, i.e. ceil(log2 p).
  function automatic logic [KW-1:0] ceil_log2(input logic [PW-1:0] p);
    logic [PW-1:0] pm1;
    logic [KW-1:0] k;
    pm1 = p - PW'(1);
    k   = '0;
    for (int b = 0; b < PW; b++) begin
      if (pm1[b]) k = KW'(b + 1);
    end
    return k;
  endfunction

  // A rank holds the block at distance d (mod p) from itself when d or d+p is
  // a multiple of the stride below 2^k.
  function automatic logic held(input logic [PW-1:0] d, input logic [PW-1:0] p,
                                input logic [QW-1:0] smask, input logic [QW-1:0] pow2k);
    logic [QW-1:0] dx;
    logic [QW-1:0] wrap;
    dx   = QW'(d);
    wrap = dx + QW'(p);
    return ((dx & smask) == '0) || ((wrap < pow2k) && ((wrap & smask) == '0));
  endfunction

  logic [bag_pkg::STEP_W-1:0] step_q;
  logic [PW-1:0] p_q, rank_q;
  logic [KW-1:0] k_q;
  logic [QW-1:0] smask_q, pow2k_q;
  logic [PW-1:0] d_src_q, d_dst_q, idx_q, pend_blk_q;
  logic [PW-1:0] send_q, recv_q;
  logic [CW-1:0] cnt_q;
  logic          pend_valid_q;

  logic                       out_valid_q, out_has_q, out_last_q, out_inv_q;
  logic [bag_pkg::RANK_W-1:0] out_blk_q, out_send_q, out_recv_q;

  // Setup arithmetic: hop = 2^(k-s-1), stride = 2^(k-s).
  logic [KW-1:0] ks;
  logic [PW-1:0] hop;
  logic [QW-1:0] stride;
  logic [QW-1:0] rp_sum;
  logic [PW-1:0] sp, rp, d_src0, d_dst0;
  logic          invalid;

  always_comb begin
    invalid = (KW'(step_q) >= k_q);
    ks      = k_q - KW'(step_q);
    hop     = PW'(1) << (ks - KW'(1));
    stride  = QW'(1) << ks;
    rp_sum  = QW'(rank_q) + QW'(hop);
    rp      = (rp_sum >= QW'(p_q)) ? PW'(rp_sum - QW'(p_q)) : PW'(rp_sum);
    sp      = (rank_q >= hop) ? (rank_q - hop) : (rank_q + p_q - hop);
    d_src0  = (rank_q == '0) ? '0 : (p_q - rank_q);
    d_dst0  = (hop >= rank_q) ? (hop - rank_q) : (hop + p_q - rank_q);
  end

  // Scan decisions for the current block.
  logic out_free, qual, need_push, stall, scan_last, push_scan, push_fin;
  logic [PW-1:0] d_src_nx, d_dst_nx;

  always_comb begin
    out_free  = !out_valid_q || out_ready_i;
    qual      = held(d_src_q, p_q, smask_q, pow2k_q) && !held(d_dst_q, p_q, smask_q, pow2k_q);
    need_push = qual && pend_valid_q;
    stall     = need_push && !out_free;
    scan_last = (idx_q == p_q - PW'(1)) || (qual && (cnt_q == CW'(bag_pkg::MAX_OUT - 1)));
    push_scan = cmd_i.scan && need_push && out_free;
    push_fin  = cmd_i.finish && out_free;
    d_src_nx  = (d_src_q == p_q - PW'(1)) ? '0 : (d_src_q + PW'(1));
    d_dst_nx  = (d_dst_q == p_q - PW'(1)) ? '0 : (d_dst_q + PW'(1));
  end

  always_comb begin
    sts_o              = '0;
    sts_o.mod_done     = (rank_q < p_q);
    sts_o.step_invalid = invalid;
    sts_o.scan_done    = cmd_i.scan && !stall && scan_last;
    sts_o.fin_done     = push_fin;
  end

  // Working registers of one step; payload only, no reset needed.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      step_q <= step_i;
      p_q    <= ranks_i;
      k_q    <= ceil_log2(ranks_i);
      rank_q <= PW'(my_rank_i);
    end
    if (cmd_i.reduce && (rank_q >= p_q)) begin
      rank_q <= rank_q - p_q;
    end
    if (cmd_i.setup) begin
      smask_q <= stride - QW'(1);
      pow2k_q <= QW'(1) << k_q;
      d_src_q <= d_src0;
      d_dst_q <= d_dst0;
      idx_q   <= '0;
      cnt_q   <= '0;
      send_q  <= invalid ? '0 : sp;
      recv_q  <= invalid ? '0 : rp;
    end
    if (cmd_i.scan && !stall) begin
      idx_q   <= idx_q + PW'(1);
      d_src_q <= d_src_nx;
      d_dst_q <= d_dst_nx;
      if (qual) begin
        pend_blk_q <= idx_q;
        cnt_q      <= cnt_q + CW'(1);
      end
    end
  end

  // Hold-stage valid bit: a found block waits until the next one, or the end
  // of the scan, tells whether it is the last.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else if (cmd_i.setup) begin
      pend_valid_q <= 1'b0;
    end else if (cmd_i.scan && !stall && qual) begin
      pend_valid_q <= 1'b1;
    end
  end

  // Output register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push_scan || push_fin) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (push_scan || push_fin) begin
      out_blk_q  <= (push_scan || pend_valid_q) ? pend_blk_q[bag_pkg::RANK_W-1:0] : '0;
      out_has_q  <= push_scan || pend_valid_q;
      out_last_q <= push_fin;
      out_send_q <= send_q[bag_pkg::RANK_W-1:0];
      out_recv_q <= recv_q[bag_pkg::RANK_W-1:0];
      out_inv_q  <= cmd_i.finish && invalid;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign block_index_o  = out_blk_q;
  assign has_block_o    = out_has_q;
  assign last_o         = out_last_q;
  assign send_peer_o    = out_send_q;
  assign recv_peer_o    = out_recv_q;
  assign step_invalid_o = out_inv_q;

  // A held block has always been counted.
  a_pend_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> (cnt_q != '0))
    else $error("held block without a count");

  // Distance counters stay reduced modulo p while scanning.
  a_dist_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan |-> ((d_src_q < p_q) && (d_dst_q < p_q)))
    else $error("scan distance out of range");

  // An empty beat always closes its step.
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_has_q) |-> out_last_q)
    else $error("empty beat without last");

  // An invalid step yields one empty beat with zero peers.
  a_invalid_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_inv_q) |->
      (!out_has_q && out_last_q && (out_send_q == '0) && (out_recv_q == '0)))
    else $error("malformed invalid-step beat");

endmodule

FILE: verif/bruck_allgather_schedule_unit_tb.sv
// Self-checking testbench for bruck_allgather_schedule_unit. A directed table runs
// first, then randomized phases over many rank settings, checked beat by beat.
// Depends on bag_pkg and the schedule unit RTL.
module bruck_allgather_schedule_unit_tb;

  localparam int MAX_RANKS     = 64;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 120;
  localparam int RANDOM_PHASES = 14;
  localparam int PHASE_ITEMS   = 33;
  localparam int HOLD_PHASE    = 3;
  localparam int PAUSE_PHASE   = 6;

  // One output beat, in port order.
  typedef struct packed {
    logic [bag_pkg::RANK_W-1:0] block_index;
    logic                       has_block;
    logic                       last;
    logic [bag_pkg::RANK_W-1:0] send_peer;
    logic [bag_pkg::RANK_W-1:0] recv_peer;
    logic                       step_invalid;
  } beat_t;

  // One directed step; typed rows carry their single expected beat.
  typedef struct packed {
    logic [bag_pkg::RANKS_W-1:0] num_ranks;
    logic [bag_pkg::RANKS_W-1:0] my_rank;
    logic [bag_pkg::STEP_W-1:0]  step;
    logic                        typed;
    beat_t                       beat;
  } row_t;

  localparam beat_t INVALID_BEAT = '{block_index: '0, has_block: 1'b0, last: 1'b1,
                                     send_peer: '0, recv_peer: '0, step_invalid: 1'b1};

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          cfg_we_i    = 1'b0;
  logic [bag_pkg::CFG_IDX_W-1:0] cfg_index_i = bag_pkg::CFG_NUM_RANKS;
  logic [bag_pkg::RANKS_W-1:0]   cfg_data_i  = '0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_ready_o;
  logic [bag_pkg::STEP_W-1:0]    step_i      = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic [bag_pkg::RANK_W-1:0]    block_index_o;
  logic                          has_block_o;
  logic                          last_o;
  logic [bag_pkg::RANK_W-1:0]    send_peer_o;
  logic [bag_pkg::RANK_W-1:0]    recv_peer_o;
  logic                          step_invalid_o;

  // Travels with the step so the checker knows when a typed expectation applies.
  logic               step_typed  = 1'b0;
  beat_t              typed_beat  = '0;

  // Register copies as the block sees them, and the beats still owed.
  logic [bag_pkg::RANKS_W-1:0] nr_mirror = 7'd2;
  logic [bag_pkg::RANK_W-1:0]  mr_mirror = 6'd0;
  beat_t                       pending_beats[$];
  int                          errors    = 0;

  // Settings last written by the sender, and the shared idling controls.
  logic [bag_pkg::RANKS_W-1:0] cur_nr = 7'd2;
  logic [bag_pkg::RANKS_W-1:0] cur_mr = 7'd0;
  bit                          gaps_on  = 1'b1;
  bit                          hold_req = 1'b0;

  row_t directed_rows [25] = '{
    '{7'd2,   7'd0,   3'd0, 1'b1, '{6'd0, 1'b1, 1'b1, 6'd1, 6'd1, 1'b0}},
    '{7'd2,   7'd0,   3'd7, 1'b1, INVALID_BEAT},
    '{7'd2,   7'd0,   3'd1, 1'b1, INVALID_BEAT},
    '{7'd64,  7'd0,   3'd0, 1'b1, '{6'd0, 1'b1, 1'b1, 6'd32, 6'd32, 1'b0}},
    '{7'd64,  7'd0,   3'd5, 1'b0, '0},
    '{7'd64,  7'd0,   3'd6, 1'b1, INVALID_BEAT},
    '{7'd64,  7'd0,   3'd7, 1'b1, INVALID_BEAT},
    '{7'd64,  7'd0,   3'd3, 1'b0, '0},
    '{7'd64,  7'd63,  3'd5, 1'b0, '0},
    '{7'd64,  7'd63,  3'd2, 1'b0, '0},
    '{7'd127, 7'd127, 3'd4, 1'b0, '0},
    '{7'd127, 7'd127, 3'd0, 1'b0, '0},
    '{7'd0,   7'd63,  3'd0, 1'b1, '{6'd1, 1'b1, 1'b1, 6'd0, 6'd0, 1'b0}},
    '{7'd0,   7'd63,  3'd2, 1'b1, INVALID_BEAT},
    '{7'd1,   7'd0,   3'd0, 1'b1, '{6'd0, 1'b1, 1'b1, 6'd1, 6'd1, 1'b0}},
    '{7'd65,  7'd64,  3'd5, 1'b0, '0},
    '{7'd65,  7'd64,  3'd1, 1'b0, '0},
    '{7'd5,   7'd3,   3'd0, 1'b0, '0},
    '{7'd5,   7'd3,   3'd1, 1'b0, '0},
    '{7'd5,   7'd3,   3'd2, 1'b0, '0},
    '{7'd5,   7'd3,   3'd3, 1'b1, INVALID_BEAT},
    '{7'd33,  7'd40,  3'd5, 1'b0, '0},
    '{7'd33,  7'd40,  3'd0, 1'b0, '0},
    '{7'd33,  7'd40,  3'd6, 1'b1, INVALID_BEAT},
    '{7'd3,   7'd2,   3'd1, 1'b0, '0}
  };

  bruck_allgather_schedule_unit #(
    .MAX_RANKS(MAX_RANKS)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .step_i        (step_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .block_index_o (block_index_o),
    .has_block_o   (has_block_o),
    .last_o        (last_o),
    .send_peer_o   (send_peer_o),
    .recv_peer_o   (recv_peer_o),
    .step_invalid_o(step_invalid_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Out-of-range rank counts are pulled into the legal range.
  function automatic int unsigned clamp_ranks(input logic [bag_pkg::RANKS_W-1:0] n);
    if (n < 2) return 2;
    if (n > MAX_RANKS) return MAX_RANKS;
    return n;
  endfunction

  // Number of schedule steps, ceil(log2 p).
  function automatic int unsigned steps_needed(input int unsigned p);
    int unsigned k;
    k = 0;
    while ((1 << k) < p) k++;
    return k;
  endfunction

  // Blocks that rank r holds going into step s.
  function automatic logic [MAX_RANKS-1:0] held_blocks(input int unsigned p, r, k, s);
    logic [MAX_RANKS-1:0] held;
    int unsigned          stride;
    int unsigned          off;
    stride = 1 << (k - s);
    held = '0;
    held[r % p] = 1'b1;
    for (off = stride; off < (1 << k); off += stride) held[(r + off) % p] = 1'b1;
    return held;
  endfunction

  // Appends one beat to the tail of the owed list.
  function automatic void owe_beat(input beat_t b);
    pending_beats.insert(pending_beats.size(), b);
  endfunction

  // Queues every beat that a step request produces under the current registers.
  function automatic void predict_step(input logic [bag_pkg::STEP_W-1:0] s);
    int unsigned          p, rank, k, hop, total, n, i;
    logic [MAX_RANKS-1:0] to_send;
    beat_t                b;
    p = clamp_ranks(nr_mirror);
    rank = mr_mirror % p;
    k = steps_needed(p);
    if (s >= k) begin
      owe_beat(INVALID_BEAT);
      return;
    end
    hop = 1 << (k - s - 1);
    b = '0;
    b.recv_peer = bag_pkg::RANK_W'((rank + hop) % p);
    b.send_peer = bag_pkg::RANK_W'((p + rank - hop) % p);
    to_send = held_blocks(p, rank, k, s) & ~held_blocks(p, b.send_peer, k, s);
    total = $countones(to_send);
    if (total > bag_pkg::MAX_OUT) total = bag_pkg::MAX_OUT;
    if (total == 0) begin
      b.last = 1'b1;
      owe_beat(b);
      return;
    end
    n = 0;
    for (i = 0; i < p && n < total; i++) begin
      if (to_send[i]) begin
        b.block_index = bag_pkg::RANK_W'(i);
        b.has_block = 1'b1;
        b.last = (n + 1 == total);
        owe_beat(b);
        n++;
      end
    end
  endfunction

  function automatic void compare_field(input string name, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // Mirror register writes, predict accepted steps and check delivered beats.
  always @(posedge clk_i) begin
    beat_t got;
    beat_t want;
    if (cfg_we_i) begin
      if (cfg_index_i == bag_pkg::CFG_NUM_RANKS) nr_mirror = cfg_data_i;
      else if (cfg_index_i == bag_pkg::CFG_MY_RANK) begin
        mr_mirror = cfg_data_i[bag_pkg::RANK_W-1:0];
      end
    end
    if (in_valid_i && in_ready_o) begin
      if (step_typed) owe_beat(typed_beat);
      else predict_step(step_i);
    end
    if (out_valid_o && out_ready_i) begin
      got = '{block_index_o, has_block_o, last_o, send_peer_o, recv_peer_o,
              step_invalid_o};
      if (pending_beats.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got %h", $time, got);
        errors++;
      end else begin
        want = pending_beats.pop_front();
        compare_field("block_index", want.block_index, got.block_index);
        compare_field("has_block", want.has_block, got.has_block);
        compare_field("last", want.last, got.last);
        compare_field("send_peer", want.send_peer, got.send_peer);
        compare_field("recv_peer", want.recv_peer, got.recv_peer);
        compare_field("step_invalid", want.step_invalid, got.step_invalid);
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (stall_left == 0) begin
        if (hold_req) begin
          stall_left = HOLD_CYCLES;
          hold_req = 1'b0;
        end else if (gaps_on && $urandom_range(0, 5) == 0) begin
          stall_left = $urandom_range(1, 9);
        end
      end
      if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Offers one step and holds it until accepted, then maybe idles a burst.
  task automatic send_step(input logic [bag_pkg::STEP_W-1:0] s, input logic typed,
                           input beat_t b);
    in_valid_i <= 1'b1;
    step_i <= s;
    step_typed <= typed;
    typed_beat <= b;
    do @(posedge clk_i); while (!in_ready_o);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  // Stops offering and waits until every owed beat has been delivered.
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_beats.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes both registers on back-to-back cycles; only called while idle.
  task automatic set_ranks(input logic [bag_pkg::RANKS_W-1:0] nr,
                           input logic [bag_pkg::RANKS_W-1:0] mr);
    cfg_we_i <= 1'b1;
    cfg_index_i <= bag_pkg::CFG_NUM_RANKS;
    cfg_data_i <= nr;
    @(posedge clk_i);
    cfg_index_i <= bag_pkg::CFG_MY_RANK;
    cfg_data_i <= mr;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_nr = nr;
    cur_mr = mr;
  endtask

  // Sender: directed table, then random phases with a fresh rank setting each.
  initial begin
    logic [bag_pkg::RANKS_W-1:0] nr, mr;
    logic [bag_pkg::STEP_W-1:0]  s;
    int unsigned                 k;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].num_ranks != cur_nr || directed_rows[i].my_rank != cur_mr) begin
        settle();
        set_ranks(directed_rows[i].num_ranks, directed_rows[i].my_rank);
      end
      send_step(directed_rows[i].step, directed_rows[i].typed, directed_rows[i].beat);
    end

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      case ($urandom_range(0, 5))
        0:       nr = $urandom_range(0, 127);
        1:       nr = 7'd64;
        2:       nr = $urandom_range(2, 9);
        3:       nr = $urandom_range(2, 16);
        4:       nr = $urandom_range(17, 64);
        default: nr = 7'd2;
      endcase
      if ($urandom_range(0, 3) == 0) mr = $urandom_range(0, 127);
      else mr = $urandom_range(0, clamp_ranks(nr) - 1);
      set_ranks(nr, mr);
      // The final phase runs flat out on both sides.
      gaps_on = (phase != RANDOM_PHASES - 1) && ($urandom_range(0, 2) != 0);
      if (phase == HOLD_PHASE) hold_req = 1'b1;
      k = steps_needed(clamp_ranks(cur_nr));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == PAUSE_PHASE && n == PHASE_ITEMS / 2) settle();
        if ($urandom_range(0, 6) == 0) s = $urandom_range(0, 7);
        else s = $urandom_range(0, k - 1);
        send_step(s, 1'b0, '0);
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
